@@ rtl/radical_inverse_macros.svh @@
// Assertion macros shared by the radical inverse RTL.
`ifndef RADICAL_INVERSE_MACROS_SVH
`define RADICAL_INVERSE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define RI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("radical_inverse: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define RI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("radical_inverse: next-cycle check failed");

`endif

@@ rtl/ri_pkg.sv @@
// Shared types and constants of the radical inverse block.
package ri_pkg;

   localparam int RECIP_BITS = 32;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_FIX  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic digit;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic digits_done;
      logic div_last;
   } status_type;

   // floor(2^32 / base); bases below two never reach the multiplier
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [3:0] base);
      logic [RECIP_BITS-1:0] r;
      case (base)
         4'd2:    r = 32'h8000_0000;
         4'd3:    r = 32'h5555_5555;
         4'd4:    r = 32'h4000_0000;
         4'd5:    r = 32'h3333_3333;
         4'd6:    r = 32'h2AAA_AAAA;
         4'd7:    r = 32'h2492_4924;
         4'd8:    r = 32'h2000_0000;
         4'd9:    r = 32'h1C71_C71C;
         4'd10:   r = 32'h1999_9999;
         4'd11:   r = 32'h1745_D174;
         4'd12:   r = 32'h1555_5555;
         4'd13:   r = 32'h13B1_3B13;
         4'd14:   r = 32'h1249_2492;
         4'd15:   r = 32'h1111_1111;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/radical_inverse.sv @@
// Top level of the radical inverse (Van der Corput / Halton) block.
// Each request beat carries a base and a sample index; one response beat returns the
// index's base-b digits mirrored about the radix point as an unsigned fraction with
// FRAC_BITS fraction bits, truncated, zero-extended to 32 bits. Index zero and bases
// below two give zero. Only the low INDEX_BITS bits of the index are used. One item
// is in work at a time: the next request is taken only after the result of the last
// one is loaded into the response register. Each digit passes once through the shared
// reciprocal multiplier and then the correction step, and the final quotient comes
// from a one-bit-per-cycle restoring divider. A finished result waits in the
// response register while the next request is taken.
module radical_inverse import ri_pkg::*; #(
   parameter int INDEX_BITS = 32,
   parameter int FRAC_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // base [3:0], index [35:4], zero [39:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // fraction [31:0]
);

   cmd_type                cmd;
   status_type             status;
   logic [FRAC_BITS-1:0]   frac;

   ri_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ri_dpath #(
      .INDEX_BITS (INDEX_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_base  (req_tdata[3:0]),
      .req_index (INDEX_BITS'(req_tdata[35:4])),
      .frac      (frac)
   );

   assign rsp_tdata = 32'(frac);

endmodule

@@ rtl/ri_dpath.sv @@
// Datapath: digit extraction by reciprocal multiply, digit reversal, long division.
`include "radical_inverse_macros.svh"

module ri_dpath import ri_pkg::*; #(
   parameter int INDEX_BITS = 32,
   parameter int FRAC_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [3:0]            req_base,
   input  logic [INDEX_BITS-1:0] req_index,
   output logic [FRAC_BITS-1:0]  frac
);

   localparam int DEN_BITS  = INDEX_BITS + 4;
   localparam int PROD_BITS = INDEX_BITS + RECIP_BITS;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);

   logic [3:0]            base_ff, base_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [DEN_BITS-1:0]   rev_ff, rev_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [FRAC_BITS-1:0]  q_ff, q_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;

   logic [INDEX_BITS-1:0] quo_est;
   logic [INDEX_BITS+3:0] quo_times_base;
   logic [INDEX_BITS-1:0] diff;
   logic [4:0]            rem_est;
   logic                  fix;
   logic [3:0]            digit_val;
   logic [INDEX_BITS-1:0] quo;
   logic [DEN_BITS+3:0]   rev_mul;
   logic [DEN_BITS+3:0]   den_mul;
   logic [DEN_BITS:0]     shl;
   logic [DEN_BITS:0]     sub;
   logic                  ge;

   // quotient estimate is low by at most one; one compare fixes it
   assign quo_est        = prod_ff[PROD_BITS-1 -: INDEX_BITS];
   assign quo_times_base = (INDEX_BITS+4)'(quo_est) * (INDEX_BITS+4)'(base_ff);
   assign diff           = idx_ff - quo_times_base[INDEX_BITS-1:0];
   assign rem_est        = diff[4:0];
   assign fix            = rem_est >= {1'b0, base_ff};
   assign digit_val      = fix ? 4'(rem_est - {1'b0, base_ff}) : rem_est[3:0];
   assign quo            = fix ? quo_est + INDEX_BITS'(1) : quo_est;

   assign rev_mul = (DEN_BITS+4)'(rev_ff) * (DEN_BITS+4)'(base_ff) + (DEN_BITS+4)'(digit_val);
   assign den_mul = (DEN_BITS+4)'(den_ff) * (DEN_BITS+4)'(base_ff);

   assign shl = {rev_ff, 1'b0};
   assign sub = shl - {1'b0, den_ff};
   assign ge  = shl >= {1'b0, den_ff};

   always_comb begin
      base_in = base_ff;
      idx_in  = idx_ff;
      rev_in  = rev_ff;
      den_in  = den_ff;
      prod_in = prod_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      frac_in = frac_ff;
      if (cmd.load) begin
         base_in = req_base;
         idx_in  = req_index;
         rev_in  = '0;
         den_in  = DEN_BITS'(1);
      end
      if (cmd.mul) begin
         prod_in = PROD_BITS'(idx_ff) * PROD_BITS'(recip_of(base_ff));
      end
      if (cmd.digit) begin
         idx_in = quo;
         rev_in = rev_mul[DEN_BITS-1:0];
         den_in = den_mul[DEN_BITS-1:0];
      end
      if (cmd.div_start) begin
         q_in   = '0;
         cnt_in = CNT_BITS'(FRAC_BITS);
      end
      // rev doubles as the division remainder
      if (cmd.div_step) begin
         rev_in = ge ? sub[DEN_BITS-1:0] : shl[DEN_BITS-1:0];
         q_in   = {q_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
      if (cmd.out_load) begin
         frac_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      idx_ff  <= idx_in;
      rev_ff  <= rev_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      frac_ff <= frac_in;
   end

   assign status.digits_done = (idx_ff == '0) || (base_ff < 4'd2);
   assign status.div_last    = cnt_ff == CNT_BITS'(1);
   assign frac               = frac_ff;

   `RI_ASSERT_NEXT(a_rev_below_den, cmd.digit, rev_ff < den_ff)
   `RI_ASSERT_NOW(a_mul_valid_base, cmd.mul, base_ff >= 4'd2 && idx_ff != '0)
   `RI_ASSERT_NEXT(a_div_count_loaded, cmd.div_start, cnt_ff == CNT_BITS'(FRAC_BITS))

endmodule

@@ rtl/ri_ctrl.sv @@
// Controller: sequences load, digit steps, division and the result register.
`include "radical_inverse_macros.svh"

module ri_ctrl import ri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      room;

   assign room       = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.digits_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.digit = 1'b1;
            state_in  = ST_MUL;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (room) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RI_ASSERT_NOW(a_load_has_room, cmd.out_load, room)
   `RI_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready, state_ff == ST_MUL)
   `RI_ASSERT_NOW(a_div_after_digits, state_ff == ST_DIV, status.digits_done)

endmodule
